// File: sv/rcgb_pkg.sv
`default_nettype none
package rcgb_pkg;

	localparam int unsigned ROW_STRIDE_DEFAULT = 320;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned ADDR_W = 16;
	localparam int unsigned COLOR_W = 8;
	localparam int unsigned RUN_W = 3;
	localparam int unsigned CODE_W = 8;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CODE_W-1:0] CODE_NEXT_COLUMN = 8'h80;

	localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MAP_LOW = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MAP_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BASE = 2'd2;

	// one vertical run of equal pixels, count is 1..7
	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [COLOR_W-1:0] color;
		logic [RUN_W-1:0] count;
	} run_t;

	localparam int unsigned RUN_T_W = ADDR_W + COLOR_W + RUN_W;

endpackage
`default_nettype wire

// File: sv/rcgb_queue.sv
`default_nettype none
module rcgb_queue
	import rcgb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire run_t push_run,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output run_t      head_run
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	run_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	logic do_push;
	logic do_pop;

	assign full = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_run = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_run;
		end
	end

endmodule
`default_nettype wire

// File: sv/rcgb_front.sv
`default_nettype none
module rcgb_front
	import rcgb_pkg::*;
#(
	parameter int unsigned ROW_STRIDE = ROW_STRIDE_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic                   glyph_start,
	input  wire logic [8:0]             start_x,
	input  wire logic [7:0]             start_y,
	input  wire logic [7:0]             glyph_columns,
	input  wire logic [CODE_W-1:0]      code_byte,
	output logic                        push,
	output run_t                        push_run,
	input  wire logic                   queue_full
);

	localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(ROW_STRIDE);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EXEC
	} state_t;

	state_t state_q;

	logic [CFG_DATA_W-1:0] color_low_q;
	logic [CFG_DATA_W-1:0] color_high_q;
	logic [ADDR_W-1:0] frame_base_q;

	logic [8:0] x_q;
	logic [7:0] y_q;
	logic [7:0] cols_in_q;
	logic [CODE_W-1:0] code_q;

	logic [ADDR_W-1:0] column_q;
	logic [ADDR_W-1:0] write_q;
	logic [7:0] columns_left_q;

	logic [ADDR_W+7:0] row_offset;
	logic [ADDR_W-1:0] glyph_base;
	logic [6:0] mul_arg;
	logic [ADDR_W+6:0] step_full;
	logic [ADDR_W-1:0] write_next;
	logic [RUN_W-1:0] run_count;
	logic [CFG_DATA_W-1:0] color_word;
	logic [COLOR_W-1:0] run_color;
	logic is_run;

	always_comb begin
		row_offset = y_q * STRIDE;
		glyph_base = frame_base_q + row_offset[ADDR_W-1:0] + {7'b0, x_q};
		run_count = code_q[6:4];
		is_run = !code_q[7];
		// skip distance or run length, both move down by whole rows
		mul_arg = is_run ? {4'b0, run_count} : code_q[6:0];
		step_full = mul_arg * STRIDE;
		write_next = write_q + step_full[ADDR_W-1:0];
		color_word = code_q[3] ? color_high_q : color_low_q;
		run_color = color_word[{code_q[2:0], 3'b000} +: COLOR_W];
	end

	assign s_tready = (state_q == ST_IDLE);
	assign push = (state_q == ST_EXEC) && (columns_left_q != '0) && is_run
		&& (run_count != '0) && !queue_full;
	assign push_run = '{address: write_q, color: run_color, count: run_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			color_low_q <= '0;
			color_high_q <= '0;
			frame_base_q <= '0;
			x_q <= '0;
			y_q <= '0;
			cols_in_q <= '0;
			code_q <= '0;
			column_q <= '0;
			write_q <= '0;
			columns_left_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COLOR_MAP_LOW: color_low_q <= cfg_data;
					CFG_COLOR_MAP_HIGH: color_high_q <= cfg_data;
					CFG_FRAME_BASE: frame_base_q <= cfg_data[ADDR_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						x_q <= start_x;
						y_q <= start_y;
						cols_in_q <= glyph_columns;
						code_q <= code_byte;
						state_q <= glyph_start ? ST_LOAD : ST_EXEC;
					end
				end
				ST_LOAD: begin
					column_q <= glyph_base;
					write_q <= glyph_base;
					columns_left_q <= cols_in_q;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (columns_left_q == '0) begin
						state_q <= ST_IDLE;
					end else if (code_q == CODE_NEXT_COLUMN) begin
						columns_left_q <= columns_left_q - 1'b1;
						column_q <= column_q + 1'b1;
						write_q <= column_q + 1'b1;
						state_q <= ST_IDLE;
					end else if (!is_run) begin
						write_q <= write_next;
						state_q <= ST_IDLE;
					end else if (run_count == '0) begin
						state_q <= ST_IDLE;
					end else if (!queue_full) begin
						write_q <= write_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/rcgb_back.sv
`default_nettype none
module rcgb_back
	import rcgb_pkg::*;
#(
	parameter int unsigned ROW_STRIDE = ROW_STRIDE_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire run_t head_run,
	output logic      pop,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output logic [ADDR_W-1:0]  pixel_address,
	output logic [COLOR_W-1:0] pixel_value,
	output logic      m_tlast
);

	localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(ROW_STRIDE);

	logic [ADDR_W-1:0] addr_q;
	logic [COLOR_W-1:0] color_q;
	logic [RUN_W-1:0] left_q;
	logic take;

	// output word moves on when empty or taken
	assign take = !m_tvalid || m_tready;
	assign pop = take && (left_q == '0) && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tlast <= 1'b0;
			pixel_address <= '0;
			pixel_value <= '0;
			addr_q <= '0;
			color_q <= '0;
			left_q <= '0;
		end else if (take) begin
			if (left_q != '0) begin
				m_tvalid <= 1'b1;
				pixel_address <= addr_q;
				pixel_value <= color_q;
				m_tlast <= (left_q == RUN_W'(1));
				addr_q <= addr_q + STRIDE;
				left_q <= left_q - 1'b1;
			end else if (head_valid) begin
				m_tvalid <= 1'b1;
				pixel_address <= head_run.address;
				pixel_value <= head_run.color;
				m_tlast <= (head_run.count == RUN_W'(1));
				addr_q <= head_run.address + STRIDE;
				color_q <= head_run.color;
				left_q <= head_run.count - 1'b1;
			end else begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/rle_column_glyph_blitter_unit.sv
// rle column glyph blitter: turns a column-major run-length glyph byte stream
// into frame buffer pixel writes.
// input words (s_*): tuser = glyph_start; tdata = start_x, start_y,
// glyph_columns, code_byte. a word with tuser set opens a glyph at
// frame_base + start_y*ROW_STRIDE + start_x and then decodes its own byte.
// output words (m_*): tdata = pixel_address, pixel_value; tlast marks the
// final pixel of one input byte. a byte gives zero to seven pixels.
// config: cfg_we/cfg_index/cfg_data write color_map_low (0), color_map_high
// (1) and frame_base (2); write only while the block is idle.
// flow: the decoder takes a byte in its idle state, decodes it in its exec
// state and then returns to idle to take the next one; a byte that opens a
// glyph first passes a load state for the base address multiply. runs go
// through a 2-entry queue to the pixel writer, which issues one pixel per
// cycle while the receiver takes each word. with queue and writer empty, a
// run goes from the exec state through the queue into the output register.
// when the receiver stalls the output word holds, the queue fills, and then
// the decoder holds s_tready low on its next run byte.
// reset clears the glyph state and the config registers; no byte is decoded
// until a glyph is opened.
`default_nettype none
module rle_column_glyph_blitter_unit
	import rcgb_pkg::*;
#(
	parameter int unsigned ROW_STRIDE = ROW_STRIDE_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [39:0]            s_tdata,  // start_x, start_y, glyph_columns, code_byte
	input  wire logic                   s_tuser,  // glyph_start
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [23:0]                 m_tdata,  // pixel_address, pixel_value
	output logic                        m_tlast   // last_pixel
);

	logic push;
	run_t push_run;
	logic queue_full;
	logic pop;
	logic head_valid;
	run_t head_run;
	logic [ADDR_W-1:0] pixel_address;
	logic [COLOR_W-1:0] pixel_value;

	rcgb_front #(
		.ROW_STRIDE(ROW_STRIDE)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.glyph_start  (s_tuser),
		.start_x      (s_tdata[8:0]),
		.start_y      (s_tdata[16:9]),
		.glyph_columns(s_tdata[24:17]),
		.code_byte    (s_tdata[32:25]),
		.push         (push),
		.push_run     (push_run),
		.queue_full   (queue_full)
	);

	rcgb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_run  (push_run),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_run  (head_run)
	);

	rcgb_back #(
		.ROW_STRIDE(ROW_STRIDE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_run     (head_run),
		.pop          (pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.pixel_address(pixel_address),
		.pixel_value  (pixel_value),
		.m_tlast      (m_tlast)
	);

	assign m_tdata = {pixel_value, pixel_address};

endmodule
`default_nettype wire
